FILE: hw/rtl/hvd_pkg.sv
// Package with the shared types, constants and score functions of the Viterbi path decoder.
`timescale 1ns / 1ps

package hvd_pkg;

    localparam int OBS_W     = 5;
    localparam int SCORE_W   = 12;
    localparam int METRIC_W  = 21;
    localparam int REG_W     = 60;
    localparam int TDATA_W   = 8;

    localparam logic [OBS_W-1:0] NULL_SYM = 5'd0;
    localparam logic signed [METRIC_W-1:0] PRIOR = -21'sd89;

    localparam logic [2:0] K_NULL_NULL  = 3'd0;
    localparam logic [2:0] K_NULL_SIG   = 3'd1;
    localparam logic [2:0] K_SIG_NULL   = 3'd2;
    localparam logic [2:0] K_SIG_SAME   = 3'd3;
    localparam logic [2:0] K_SIG_OTHER  = 3'd4;

    localparam logic REG_EMIS  = 1'b0;
    localparam logic REG_TRANS = 1'b1;

    typedef enum logic [2:0] {
        A_IDLE, A_SEED, A_READ, A_ACC, A_WRITE, A_BEST, A_DONE
    } t_acs_state;

    typedef enum logic [2:0] {
        R_IDLE, R_RD, R_SEL, E_RD, E_LD, E_OUT
    } t_trc_state;

    typedef enum logic [1:0] {
        T_IDLE, T_ACS, T_TRACE
    } t_top_state;

    typedef struct packed {
        logic             start;
        logic             seed;
        logic             bank;
        logic             last_smp;
        logic [OBS_W-1:0] obs;
    } t_acs_cmd;

    function automatic logic signed [SCORE_W-1:0] score_field(
        input logic [REG_W-1:0] regv, input logic [2:0] k);
        score_field = regv[k*SCORE_W +: SCORE_W];
    endfunction

    function automatic logic [2:0] pair_code(
        input logic [OBS_W-1:0] a, input logic [OBS_W-1:0] b);
        if (a == NULL_SYM) begin
            pair_code = (b == NULL_SYM) ? K_NULL_NULL : K_NULL_SIG;
        end else if (b == NULL_SYM) begin
            pair_code = K_SIG_NULL;
        end else begin
            pair_code = (a == b) ? K_SIG_SAME : K_SIG_OTHER;
        end
    endfunction

    function automatic logic signed [SCORE_W-1:0] emis_score(
        input logic [REG_W-1:0] regv, input logic [OBS_W-1:0] obs,
        input logic [OBS_W-1:0] st);
        emis_score = score_field(regv, pair_code(obs, st));
    endfunction

    function automatic logic signed [SCORE_W-1:0] trans_score(
        input logic [REG_W-1:0] regv, input logic [OBS_W-1:0] src,
        input logic [OBS_W-1:0] dst);
        trans_score = score_field(regv, pair_code(src, dst));
    endfunction

endpackage

FILE: hw/rtl/hvd_acs.sv
// Add-compare-select array with the path metric memory and the best end state search.
`timescale 1ns / 1ps

module hvd_acs #(
    parameter int NUM_STATES = 17,
    localparam int SW = $clog2(NUM_STATES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hvd_pkg::t_acs_cmd             i_cmd,
    input  logic [hvd_pkg::REG_W-1:0]     i_emis_reg,
    input  logic [hvd_pkg::REG_W-1:0]     i_trans_reg,
    output logic                          o_done,
    output logic [NUM_STATES*SW-1:0]      o_surv_row,
    output logic [SW-1:0]                 o_best
);
    import hvd_pkg::*;

    localparam int ROW_W = NUM_STATES*METRIC_W;

    t_acs_state r_state, n_state;

    logic [ROW_W-1:0] r_mem [2];
    logic [ROW_W-1:0] r_rd;
    logic             mem_we;
    logic [ROW_W-1:0] new_row;

    logic [OBS_W-1:0] r_obs;
    logic             r_seed;
    logic             r_bank;
    logic             r_last;
    logic [SW-1:0]    r_j;

    logic signed [METRIC_W-1:0] r_acc_v [NUM_STATES];
    logic [SW-1:0]              r_acc_p [NUM_STATES];
    logic signed [METRIC_W-1:0] r_new   [NUM_STATES];
    logic signed [METRIC_W-1:0] r_bestv;
    logic [SW-1:0]              r_best;
    logic [NUM_STATES*SW-1:0]   r_surv;

    logic signed [METRIC_W-1:0] m_j;
    logic signed [METRIC_W-1:0] cand     [NUM_STATES];
    logic                       upd      [NUM_STATES];
    logic signed [METRIC_W-1:0] new_v    [NUM_STATES];
    logic                       j_end;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_bank] <= new_row;
        end
        r_rd <= r_mem[~r_bank];
    end

    always_comb begin
        m_j   = r_rd[r_j*METRIC_W +: METRIC_W];
        j_end = (r_j == SW'(NUM_STATES-1));
        for (int i = 0; i < NUM_STATES; i++) begin
            cand[i] = m_j + METRIC_W'(trans_score(i_trans_reg, OBS_W'(r_j), OBS_W'(i)));
            upd[i]  = (r_j == '0) || (cand[i] > r_acc_v[i]);
            if (r_seed) begin
                new_v[i] = PRIOR + METRIC_W'(emis_score(i_emis_reg, r_obs, OBS_W'(i)));
            end else begin
                new_v[i] = r_acc_v[i] + METRIC_W'(emis_score(i_emis_reg, r_obs, OBS_W'(i)));
            end
            new_row[i*METRIC_W +: METRIC_W] = new_v[i];
        end
    end

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            A_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.seed ? A_SEED : A_READ;
                end
            end
            A_SEED: begin
                mem_we  = 1'b1;
                n_state = r_last ? A_BEST : A_DONE;
            end
            A_READ: begin
                n_state = A_ACC;
            end
            A_ACC: begin
                if (j_end) begin
                    n_state = A_WRITE;
                end
            end
            A_WRITE: begin
                mem_we  = 1'b1;
                n_state = r_last ? A_BEST : A_DONE;
            end
            A_BEST: begin
                if (j_end) begin
                    n_state = A_DONE;
                end
            end
            A_DONE: begin
                o_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                r_obs  <= i_cmd.obs;
                r_seed <= i_cmd.seed;
                r_bank <= i_cmd.bank;
                r_last <= i_cmd.last_smp;
                r_j    <= '0;
            end
            A_ACC: begin
                for (int i = 0; i < NUM_STATES; i++) begin
                    if (upd[i]) begin
                        r_acc_v[i] <= cand[i];
                        r_acc_p[i] <= r_j;
                    end
                end
                r_j <= j_end ? '0 : r_j + 1'b1;
            end
            A_SEED, A_WRITE: begin
                for (int i = 0; i < NUM_STATES; i++) begin
                    r_new[i] <= new_v[i];
                    r_surv[i*SW +: SW] <= r_acc_p[i];
                end
                r_bestv <= new_v[0];
                r_best  <= '0;
                r_j     <= SW'(1);
            end
            A_BEST: begin
                if (r_new[r_j] > r_bestv) begin
                    r_bestv <= r_new[r_j];
                    r_best  <= r_j;
                end
                r_j <= r_j + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_surv_row = r_surv;
    assign o_best     = r_best;

endmodule

FILE: hw/rtl/hvd_trc.sv
// Survivor memory, traceback sequencer and path buffer that streams the decoded states.
`timescale 1ns / 1ps

module hvd_trc #(
    parameter int MAX_LEN    = 64,
    parameter int NUM_STATES = 17,
    localparam int SW = $clog2(NUM_STATES),
    localparam int AW = $clog2(MAX_LEN),
    localparam int CW = $clog2(MAX_LEN+1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_surv_we,
    input  logic [AW-1:0]                   i_surv_addr,
    input  logic [NUM_STATES*SW-1:0]        i_surv_row,
    input  logic                            i_start,
    input  logic [CW-1:0]                   i_len,
    input  logic [SW-1:0]                   i_best,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [hvd_pkg::TDATA_W-1:0]     o_tdata,
    output logic                            o_tlast,
    output logic                            o_done
);
    import hvd_pkg::*;

    t_trc_state r_state, n_state;

    logic [NUM_STATES*SW-1:0] r_surv_mem [MAX_LEN];
    logic [NUM_STATES*SW-1:0] r_surv_rd;
    logic [SW-1:0]            r_path_mem [MAX_LEN];
    logic [SW-1:0]            r_path_rd;

    logic [AW-1:0] r_k;
    logic [AW-1:0] r_p;
    logic [AW-1:0] r_nl;
    logic [SW-1:0] r_best;
    logic [SW-1:0] r_out;
    logic          r_valid;
    logic          r_tlast;

    logic          path_we;
    logic [AW-1:0] path_waddr;
    logic [SW-1:0] path_wdata;
    logic [AW-1:0] len_m1;
    logic [SW-1:0] nb;
    logic [CW-1:0] len_dec;

    always_comb begin
        len_dec = i_len - 1'b1;
        len_m1  = len_dec[AW-1:0];
        nb      = r_surv_rd[r_best*SW +: SW];
    end

    always_ff @(posedge i_clk) begin
        if (i_surv_we) begin
            r_surv_mem[i_surv_addr] <= i_surv_row;
        end
        r_surv_rd <= r_surv_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) begin
            r_path_mem[path_waddr] <= path_wdata;
        end
        r_path_rd <= r_path_mem[r_p];
    end

    always_comb begin
        n_state    = r_state;
        path_we    = 1'b0;
        path_waddr = r_k - 1'b1;
        path_wdata = nb;
        o_done     = 1'b0;
        unique case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    path_we    = 1'b1;
                    path_waddr = len_m1;
                    path_wdata = i_best;
                    n_state    = (len_m1 == '0) ? E_RD : R_RD;
                end
            end
            R_RD: begin
                n_state = R_SEL;
            end
            R_SEL: begin
                path_we = 1'b1;
                n_state = (r_k == AW'(1)) ? E_RD : R_RD;
            end
            E_RD: begin
                n_state = E_LD;
            end
            E_LD: begin
                n_state = E_OUT;
            end
            E_OUT: begin
                if (i_tready) begin
                    o_done  = r_tlast;
                    n_state = r_tlast ? R_IDLE : E_RD;
                end
            end
            default: n_state = R_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == E_LD) begin
                r_valid <= 1'b1;
            end else if (r_state == E_OUT && i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            R_IDLE: begin
                r_k    <= len_m1;
                r_nl   <= len_m1;
                r_best <= i_best;
                r_p    <= '0;
            end
            R_SEL: begin
                r_best <= nb;
                r_k    <= r_k - 1'b1;
            end
            E_LD: begin
                r_out   <= r_path_rd;
                r_tlast <= (r_p == r_nl);
            end
            E_OUT: begin
                if (i_tready) begin
                    r_p <= r_p + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = TDATA_W'(r_out);
    assign o_tlast  = r_tlast;

endmodule

FILE: hw/rtl/hmm_viterbi_path_decoder_top.sv
// Top level of the Viterbi path decoder for a hidden Markov model.
`timescale 1ns / 1ps

// Observations arrive on the slave stream, one per transfer: tdata holds the
// observed symbol and tlast marks the final sample of a sequence. The two
// score registers are written through the configuration channel while the
// block is idle. Each sample is taken by one add-compare-select pass: the
// previous metric row is read from the metric memory and NUM_STATES
// parallel units step through the source states, one per cycle; a first
// sample instead seeds the row from the prior. The final sample adds the
// best end state search. Traceback then walks the survivor memory back one
// sample at a time, and the path is streamed first to last, each state read
// only after the receiver takes the last; tlast marks the final state.
// While a receiver stalls, the current result holds and no new sample is
// taken. A sequence that reaches MAX_LEN samples without tlast closes there.
// Reset clears the control state, the sample count and the score registers;
// the memories need no clearing.
module hmm_viterbi_path_decoder_top #(
    parameter int MAX_LEN    = 64,
    parameter int NUM_STATES = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [hvd_pkg::TDATA_W-1:0]   i_s_tdata,   // [4:0] observation
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [hvd_pkg::TDATA_W-1:0]   o_m_tdata,   // [4:0] path_state
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [hvd_pkg::REG_W-1:0]     i_cfg_data
);
    import hvd_pkg::*;

    localparam int SW = $clog2(NUM_STATES);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN+1);

    t_top_state r_state, n_state;

    logic [REG_W-1:0] r_emis;
    logic [REG_W-1:0] r_trans;
    logic [AW-1:0]    r_cnt;
    logic             r_final;

    t_acs_cmd                 acs_cmd;
    logic                     acs_done;
    logic [NUM_STATES*SW-1:0] surv_row;
    logic [SW-1:0]            best;
    logic                     trc_done;
    logic                     trc_start;
    logic                     s_acc;
    logic                     is_final;
    logic [CW-1:0]            len;

    assign o_cfg_ready = (r_state == T_IDLE);
    assign o_s_tready  = (r_state == T_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign is_final    = i_s_tlast || (r_cnt == AW'(MAX_LEN-1));
    assign len         = CW'(r_cnt) + 1'b1;
    assign trc_start   = (r_state == T_ACS) && acs_done && r_final;

    always_comb begin
        acs_cmd.start    = s_acc;
        acs_cmd.seed     = (r_cnt == '0);
        acs_cmd.bank     = r_cnt[0];
        acs_cmd.last_smp = is_final;
        acs_cmd.obs      = i_s_tdata[OBS_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (s_acc) begin
                    n_state = T_ACS;
                end
            end
            T_ACS: begin
                if (acs_done) begin
                    n_state = r_final ? T_TRACE : T_IDLE;
                end
            end
            T_TRACE: begin
                if (trc_done) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cnt   <= '0;
            r_final <= 1'b0;
            r_emis  <= '0;
            r_trans <= '0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_final <= is_final;
            end
            if (r_state == T_ACS && acs_done) begin
                r_cnt <= r_final ? '0 : r_cnt + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_EMIS:  r_emis  <= i_cfg_data;
                    REG_TRANS: r_trans <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    hvd_acs #(
        .NUM_STATES(NUM_STATES)
    ) u_acs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (acs_cmd),
        .i_emis_reg  (r_emis),
        .i_trans_reg (r_trans),
        .o_done      (acs_done),
        .o_surv_row  (surv_row),
        .o_best      (best)
    );

    hvd_trc #(
        .MAX_LEN    (MAX_LEN),
        .NUM_STATES (NUM_STATES)
    ) u_trc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_surv_we   ((r_state == T_ACS) && acs_done),
        .i_surv_addr (r_cnt),
        .i_surv_row  (surv_row),
        .i_start     (trc_start),
        .i_len       (len),
        .i_best      (best),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata),
        .o_tlast     (o_m_tlast),
        .o_done      (trc_done)
    );

endmodule
